// ===== hw/rtl/skag_pkg.sv =====
// Package for the seed/key access gate: payload structs, response codes,
// register indexes and security state constants. No dependencies.

package skag_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SEED_ONE   = 3'd0;
    localparam logic [2:0] REG_SEED_THREE = 3'd1;
    localparam logic [2:0] REG_SEED_FIVE  = 3'd2;
    localparam logic [2:0] REG_SEED_SEVEN = 3'd3;
    localparam logic [2:0] REG_KEY_ONE    = 3'd4;
    localparam logic [2:0] REG_KEY_TWO    = 3'd5;
    localparam logic [2:0] REG_KEY_THREE  = 3'd6;
    localparam logic [2:0] REG_KEY_FOUR   = 3'd7;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    // Response codes
    localparam logic [2:0] RC_OK          = 3'd0;
    localparam logic [2:0] RC_LENGTH      = 3'd1;
    localparam logic [2:0] RC_UNSUPPORTED = 3'd2;
    localparam logic [2:0] RC_SEQUENCE    = 3'd3;
    localparam logic [2:0] RC_BAD_KEY     = 3'd4;
    localparam logic [2:0] RC_DELAY       = 3'd5;

    // Security state constants
    localparam logic [7:0] LOCKOUT        = 8'hFF;
    localparam logic [8:0] TRY_STEP       = 9'h010;
    localparam logic [8:0] TRY_LIMIT      = 9'h030;
    localparam logic [7:0] TOP_SEED_LEVEL = 8'h07;
    localparam logic [7:0] TOP_KEY_LEVEL  = 8'h08;

    typedef struct packed {
        logic [7:0]  sub_function;
        logic [11:0] message_length;
        logic [63:0] key_bytes;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  echo_level;
        logic        seed_valid;
        logic [63:0] seed_value;
        logic [2:0]  response_code;
        logic [7:0]  access_state;
    } t_rsp;

endpackage

// ===== hw/rtl/seed_key_access_gate.sv =====
// Seed/key security access gate, top level.
// Depends on skag_pkg for payload structs, codes and constants.

// Usage
//   Requests arrive on i_in_valid / i_in_data and are taken at an edge where
//   o_in_stall is low. Each request gives exactly one response on
//   o_out_valid / o_out_data, taken at an edge where i_out_stall is low.
//   A request lands in the input register; from there it is decided against
//   the security state and the result loads the result register. Throughput
//   is one request per cycle while the receiver does not stall; the limit is
//   the single read-modify-write of the security state register per decision.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; o_in_stall rises only once both
//   are full, and falls in the same cycle the receiver releases.
//   The user writes the seed and key registers via i_cfg_wr_en, i_cfg_idx
//   and i_cfg_data while the block is idle (not enforced); no read-back.
//   Reset (synchronous, i_rst_n low) empties both registers, clears the
//   security state to zero (locked, no level) and clears all seeds and keys.

module seed_key_access_gate
    import skag_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rsp                  o_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;
    logic [7:0]  r_state;
    logic [7:0]  n_state;
    logic [63:0] r_seed [4];
    logic [63:0] r_key  [4];

    logic        w_out_load;
    logic        w_adv;
    logic        w_in_take;
    t_rsp        n_out;

    logic        w_odd;
    logic [8:0]  w_next_level;
    logic        w_in_seq;
    logic [8:0]  w_bump_sum;
    logic [7:0]  w_bump;
    logic [1:0]  w_key_slot;
    logic        w_key_ok;

    // Handshake: result register loads when empty or being drained
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_in_stall = r_in_valid && !w_out_load;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_seed[i] <= '0;
                r_key[i]  <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_SEED_ONE:   r_seed[0] <= i_cfg_data;
                REG_SEED_THREE: r_seed[1] <= i_cfg_data;
                REG_SEED_FIVE:  r_seed[2] <= i_cfg_data;
                REG_SEED_SEVEN: r_seed[3] <= i_cfg_data;
                REG_KEY_ONE:    r_key[0]  <= i_cfg_data;
                REG_KEY_TWO:    r_key[1]  <= i_cfg_data;
                REG_KEY_THREE:  r_key[2]  <= i_cfg_data;
                REG_KEY_FOUR:   r_key[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Helpers for the decision
    assign w_odd        = r_in.sub_function[0];
    assign w_next_level = {1'b0, r_state} + 9'd1;
    assign w_in_seq     = ({1'b0, r_in.sub_function} == w_next_level);
    assign w_bump_sum   = {1'b0, r_state} + TRY_STEP;
    assign w_bump       = (w_bump_sum >= TRY_LIMIT) ? LOCKOUT : w_bump_sum[7:0];
    // even levels 0,2 -> slot 0; 4 -> 1; 6 -> 2; 8 -> 3
    assign w_key_slot   = (r_in.sub_function[3:1] == 3'd0) ? 2'd0
                        : 2'(r_in.sub_function[3:1] - 3'd1);
    assign w_key_ok     = (r_in.sub_function <= TOP_KEY_LEVEL)
                        && (r_key[w_key_slot] == r_in.key_bytes);

    // Decision, checks in priority order
    always_comb begin
        n_state             = r_state;
        n_out.accepted      = 1'b0;
        n_out.echo_level    = r_in.sub_function;
        n_out.seed_valid    = 1'b0;
        n_out.seed_value    = '0;
        n_out.response_code = RC_OK;
        if (r_in.message_length == 12'd0 || (!w_odd && r_in.message_length < 12'd2)) begin
            n_out.response_code = RC_LENGTH;
        end else if (w_odd && r_in.sub_function > TOP_SEED_LEVEL) begin
            n_out.response_code = RC_UNSUPPORTED;
        end else if (r_state == LOCKOUT) begin
            n_out.response_code = RC_DELAY;
        end else if (w_odd) begin
            if (w_in_seq) begin
                n_out.accepted   = 1'b1;
                n_out.seed_valid = 1'b1;
                n_out.seed_value = r_seed[r_in.sub_function[2:1]];
                n_state          = w_next_level[7:0];
            end else begin
                n_out.response_code = (r_in.sub_function < r_state) ? RC_UNSUPPORTED
                                                                     : RC_SEQUENCE;
                n_state             = w_bump;
            end
        end else begin
            if (w_key_ok && w_in_seq) begin
                n_out.accepted = 1'b1;
                n_state        = w_next_level[7:0];
            end else begin
                n_out.response_code = RC_BAD_KEY;
                n_state             = w_bump;
            end
        end
        n_out.access_state = n_state;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Lockout is sticky until reset
    a_lockout_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == LOCKOUT |=> r_state == LOCKOUT)
        else $error("security state left lockout");

    // State moves only when a request is decided
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("security state changed without a decision");

    // A positive response carries code ok, and a seed only with success
    a_accept_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.accepted |-> o_out_data.response_code == RC_OK)
        else $error("accepted response with non-ok code");

    a_seed_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.seed_valid |-> o_out_data.accepted)
        else $error("seed returned on a negative response");

    // Decided response reports the state it left behind
    a_state_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_data.access_state == r_state)
        else $error("reported state differs from stored state");

endmodule

// ===== test/seed_key_access_gate_tb.sv =====
// Testbench for seed_key_access_gate. It predicts each response from its own model of the
// security state and the eight seed and key registers. Depends on skag_pkg and the RTL only.
`timescale 1ns / 100ps

module seed_key_access_gate_tb;
    import skag_pkg::*;

    localparam int NUM_REGS        = 8;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 40;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    t_req                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    t_rsp                  rsp_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor state: register copies and the security state byte
    logic [63:0] gate_regs [NUM_REGS];
    logic [63:0] cfg_image [NUM_REGS];
    logic [7:0]  access_level = 8'h00;
    t_rsp        pending_responses [$];

    // Idling controls and run counters
    int unsigned req_gap_pct   = 24;
    int unsigned rsp_stall_pct = 59;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    logic        req_offered   = 1'b0;
    int          idle_cycles   = 0;
    int          error_count   = 0;
    int          request_count = 0;
    int          response_count = 0;
    int          granted_count = 0;
    int          locked_count  = 0;
    int          config_writes = 0;

    seed_key_access_gate i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Each failed try adds one step; three steps or more means lockout
    function automatic logic [7:0] count_failure(input logic [7:0] level);
        logic [8:0] sum;
        sum = {1'b0, level} + TRY_STEP;
        if (sum >= TRY_LIMIT) begin
            return LOCKOUT;
        end
        return sum[7:0];
    endfunction

    // Decide one request against the security state, updating it as the block would
    function automatic t_rsp decide_access(input t_req req);
        t_rsp rsp;
        logic odd;
        logic in_order;
        logic key_ok;
        int   slot;
        rsp = '0;
        rsp.echo_level = req.sub_function;
        rsp.response_code = RC_OK;
        odd = req.sub_function[0];
        in_order = ({1'b0, req.sub_function} == {1'b0, access_level} + 9'd1);
        if (req.message_length == 12'd0 || (!odd && req.message_length < 12'd2)) begin
            rsp.response_code = RC_LENGTH;
        end else if (odd && req.sub_function > TOP_SEED_LEVEL) begin
            rsp.response_code = RC_UNSUPPORTED;
        end else if (access_level == LOCKOUT) begin
            rsp.response_code = RC_DELAY;
        end else if (odd) begin
            if (in_order) begin
                rsp.accepted = 1'b1;
                rsp.seed_valid = 1'b1;
                rsp.seed_value = gate_regs[req.sub_function[2:1]];
                access_level = access_level + 8'd1;
            end else begin
                rsp.response_code = (req.sub_function < access_level) ? RC_UNSUPPORTED
                                                                        : RC_SEQUENCE;
                access_level = count_failure(access_level);
            end
        end else begin
            // Level zero shares the first key pair; even levels above eight never match
            if (req.sub_function > TOP_KEY_LEVEL) begin
                key_ok = 1'b0;
            end else begin
                slot = (req.sub_function == 8'd0) ? 0 : (req.sub_function - 1) / 2;
                key_ok = (gate_regs[int'(REG_KEY_ONE) + slot] == req.key_bytes);
            end
            if (key_ok && in_order) begin
                rsp.accepted = 1'b1;
                access_level = access_level + 8'd1;
            end else begin
                rsp.response_code = RC_BAD_KEY;
                access_level = count_failure(access_level);
            end
        end
        rsp.access_state = access_level;
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] response %0d: %s", $realtime, response_count, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
        end
    endtask

    // Response checker: compare each transfer with the oldest prediction
    always @(posedge clk) begin : check_responses
        t_rsp want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            response_count++;
            if (pending_responses.size() == 0) begin
                report_mismatch("response transfer with nothing pending");
            end else begin
                want = pending_responses.pop_front();
                check_field("accepted", rsp_data.accepted, want.accepted);
                check_field("echo_level", rsp_data.echo_level, want.echo_level);
                check_field("seed_valid", rsp_data.seed_valid, want.seed_valid);
                check_field("seed_value", rsp_data.seed_value, want.seed_value);
                check_field("response_code", rsp_data.response_code, want.response_code);
                check_field("access_state", rsp_data.access_state, want.access_state);
                if (want.accepted) granted_count++;
                if (want.response_code == RC_DELAY) locked_count++;
            end
        end
    end

    // Receiver stall: random, or a long hold-off when a test asks for one
    always @(posedge clk) begin : drive_rsp_stall
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge clk) begin : watchdog
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     idle_cycles, pending_responses.size());
            $display("seed_key_access_gate_tb: done, errors");
            $finish;
        end
    end

    task automatic drop_valid();
        if (req_offered) begin
            req_valid <= 1'b0;
            req_offered = 1'b0;
        end
    endtask

    // One request transfer; valid stays up afterwards so back-to-back items need no gap
    task automatic send_request(input t_req req);
        while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
            drop_valid();
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= req;
        req_offered = 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pending_responses.push_back(decide_access(req));
        request_count++;
    endtask

    task automatic send_fields(input logic [7:0] sub, input logic [11:0] len,
                               input logic [63:0] key);
        t_req req;
        req.sub_function = sub;
        req.message_length = len;
        req.key_bytes = key;
        send_request(req);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_responses.size() != 0) @(posedge clk);
    endtask

    // Write every register from cfg_image once the block has gone quiet
    task automatic apply_config();
        int r;
        wait_drained();
        for (r = 0; r < NUM_REGS; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_idx <= r[CFG_IDX_W-1:0];
            cfg_data <= cfg_image[r];
            @(posedge clk);
            gate_regs[r] = cfg_image[r];
            config_writes++;
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Four in ten well-formed requests with the right key, three malformed, the rest raw fields
    function automatic t_req random_request();
        t_req req;
        logic [7:0] level;
        int pick;
        req.sub_function = 8'($urandom());
        req.message_length = 12'($urandom());
        req.key_bytes = {$urandom(), $urandom()};
        pick = $urandom_range(9);
        if (pick < 4) begin
            level = 8'($urandom_range(1, TOP_KEY_LEVEL));
            req.sub_function = level;
            if (level[0]) begin
                req.message_length = 12'($urandom_range(1, 4095));
            end else begin
                req.message_length = 12'($urandom_range(2, 4095));
                req.key_bytes = gate_regs[int'(REG_KEY_ONE) + (level - 1) / 2];
            end
        end else if (pick < 7) begin
            case ($urandom_range(2))
                0: begin
                    req.message_length = 12'd0;
                end
                1: begin
                    req.sub_function[0] = 1'b0;
                    req.message_length = 12'd1;
                end
                default: begin
                    req.sub_function = 8'($urandom_range(4, 127) * 2 + 1);
                    req.message_length = 12'($urandom_range(1, 4095));
                end
            endcase
        end
        return req;
    endfunction

    // Malformed lengths and unsupported seed levels leave the state alone
    task automatic test_reject_malformed();
        send_fields(8'd1, 12'd0, '1);
        send_fields(8'd2, 12'd1, '0);
        send_fields(8'd0, 12'd0, '0);
        send_fields(8'hFE, 12'd1, '1);
        send_fields(8'd9, 12'd4095, '0);
        send_fields(8'hFF, 12'd1, '1);
        send_fields(8'h81, 12'd4095, 64'hA5A5_5A5A_0F0F_F0F0);
    endtask

    // Climb every level in order, changing the registers halfway up
    task automatic test_level_ladder();
        cfg_image[REG_SEED_ONE]   = '1;
        cfg_image[REG_SEED_THREE] = '0;
        cfg_image[REG_SEED_FIVE]  = 64'h0123_4567_89AB_CDEF;
        cfg_image[REG_SEED_SEVEN] = 64'h8000_0000_0000_0001;
        cfg_image[REG_KEY_ONE]    = '0;
        cfg_image[REG_KEY_TWO]    = '1;
        cfg_image[REG_KEY_THREE]  = 64'hDEAD_BEEF_0BAD_F00D;
        cfg_image[REG_KEY_FOUR]   = 64'h5A5A_A5A5_C3C3_3C3C;
        apply_config();
        send_fields(8'd1, 12'd1, '0);
        send_fields(8'd2, 12'd2, gate_regs[REG_KEY_ONE]);
        send_fields(8'd3, 12'd4095, '1);
        send_fields(8'd4, 12'd4095, gate_regs[REG_KEY_TWO]);
        cfg_image[REG_SEED_ONE]   = '0;
        cfg_image[REG_SEED_THREE] = '1;
        cfg_image[REG_SEED_FIVE]  = 64'hFEDC_BA98_7654_3210;
        cfg_image[REG_SEED_SEVEN] = '1;
        cfg_image[REG_KEY_ONE]    = '1;
        cfg_image[REG_KEY_TWO]    = '0;
        cfg_image[REG_KEY_THREE]  = '1;
        cfg_image[REG_KEY_FOUR]   = {$urandom(), $urandom()};
        apply_config();
        send_fields(8'd5, 12'd1, {$urandom(), $urandom()});
        send_fields(8'd6, 12'd1, gate_regs[REG_KEY_THREE]);
        send_fields(8'd6, 12'd2, gate_regs[REG_KEY_THREE]);
        send_fields(8'd7, 12'd9, '0);
        send_fields(8'd8, 12'd9, gate_regs[REG_KEY_FOUR]);
    endtask

    // Three failed tries from the top level, then everything refused in lockout
    task automatic test_failures_to_lockout();
        // even level above eight never matches, even with a stored key
        send_fields(8'd10, 12'd9, gate_regs[REG_KEY_FOUR]);
        // seed request below the state: not supported, still a failed try
        send_fields(TOP_SEED_LEVEL, 12'd1, '0);
        // level zero compares against the first pair but is never in sequence
        send_fields(8'd0, 12'd2, gate_regs[REG_KEY_ONE]);
        send_fields(8'd1, 12'd1, '0);
        send_fields(8'd2, 12'd9, gate_regs[REG_KEY_ONE]);
        send_fields(8'd2, 12'd1, '1);
        send_fields(8'd11, 12'd5, '1);
    endtask

    task automatic test_random_requests(input int count, input int unsigned gap_pct,
                                        input int unsigned stall_pct,
                                        input logic [63:0] fill, input logic [63:0] scatter);
        int n;
        for (n = 0; n < NUM_REGS; n++) begin
            cfg_image[n] = fill ^ ({$urandom(), $urandom()} & scatter);
        end
        apply_config();
        req_gap_pct = gap_pct;
        rsp_stall_pct <= stall_pct;
        for (n = 0; n < count; n++) begin
            send_request(random_request());
        end
    endtask

    // Long receiver hold-off fills the block; then a full pause until all is back
    task automatic test_backpressure();
        int n;
        req_gap_pct = 0;
        rsp_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        for (n = 0; n < 24; n++) send_request(random_request());
        wait_drained();
        for (n = 0; n < 24; n++) send_request(random_request());
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reject_malformed();
        test_level_ladder();
        test_failures_to_lockout();
        test_random_requests(660, 24, 59, '0, '0);
        test_backpressure();
        test_random_requests(660, 59, 24, '1, '0);
        test_random_requests(660, 0, 0, '0, '1);
        wait_drained();
        repeat (4) @(posedge clk);
        $display("covered %0d requests and %0d responses: %0d granted, %0d refused in lockout",
                 request_count, response_count, granted_count, locked_count);
        $display("%0d register writes over five settings, %0d mismatches",
                 config_writes, error_count);
        if (error_count == 0 && pending_responses.size() == 0) begin
            $display("seed_key_access_gate_tb: done, clean");
        end else begin
            $display("seed_key_access_gate_tb: done, errors");
        end
        $finish;
    end

endmodule
